// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the scheduler top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked on clk, quiet during reset.
`define PES_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scheduler assertion failed");

// Next-cycle implication, checked on clk, quiet during reset.
`define PES_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scheduler assertion failed");

`else

`define PES_ASSERT_NOW(label, ante, cons)
`define PES_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== hw/rtl/pes_pkg.sv =====
// Shared types and constants of the periodic event scheduler.
package pes_pkg;

  // Default table depth; the design supports 2 to 256 entries.
  localparam int MAX_USERS_DEF = 16;
  // Count field width in the command beat, wide enough for 256 entries.
  localparam int CNT_W = 9;
  // Depth of the command and result queues.
  localparam int Q_DEPTH = 2;

  // Request codes.
  localparam logic [1:0] REQ_ADD   = 2'd0;
  localparam logic [1:0] REQ_NEXT  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] user_id;
    logic [15:0] period;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] event_id;
    logic [31:0] event_time;
  } out_beat_t;

  // Work handed from front to back.
  typedef enum logic [1:0] {
    CMD_RESP = 2'd0,  // result is known already, just report status
    CMD_ADD  = 2'd1,  // store entry at slot given by count
    CMD_NEXT = 2'd2   // scan count entries, fire earliest
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t          op;
    logic [1:0]       status;
    logic [CNT_W-1:0] count;
    logic [15:0]      user_id;
    logic [15:0]      period;
  } cmd_t;

  // One table entry as stored in RAM.
  typedef struct packed {
    logic [15:0] id;
    logic [15:0] period;
    logic [31:0] next_time;
  } entry_t;

endpackage

// ===== hw/rtl/pes_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pes_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// ===== hw/rtl/pes_fifo.sv =====
// Small synchronous queue used between front, back and result port.
module pes_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wptr_r, wptr_nxt;
  logic [PW-1:0]    rptr_r, rptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rptr_r];

  // pointer and fill updates
  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + PW'(1);
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // storage, no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

endmodule

// ===== hw/rtl/pes_front.sv =====
// Front end: tracks the entry count and classifies each request beat.
module pes_front #(
  parameter int MAX_USERS = pes_pkg::MAX_USERS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  pes_pkg::in_beat_t req,
  output pes_pkg::cmd_t     cmd
);

  localparam int CNTW = $clog2(MAX_USERS + 1);
  localparam int CW   = pes_pkg::CNT_W;

  logic [CNTW-1:0] cnt_r, cnt_nxt;

  // classify request against the current count
  always_comb begin
    cmd.op      = pes_pkg::CMD_RESP;
    cmd.status  = pes_pkg::ST_OK;
    cmd.count   = CW'(cnt_r);
    cmd.user_id = req.user_id;
    cmd.period  = req.period;
    cnt_nxt     = cnt_r;
    case (req.req_type)
      pes_pkg::REQ_ADD: begin
        if (cnt_r == CNTW'(MAX_USERS)) begin
          cmd.status = pes_pkg::ST_FULL;
        end else begin
          cmd.op  = pes_pkg::CMD_ADD;
          cnt_nxt = cnt_r + CNTW'(1);
        end
      end
      pes_pkg::REQ_NEXT: begin
        if (cnt_r == '0) begin
          cmd.status = pes_pkg::ST_EMPTY;
        end else begin
          cmd.op = pes_pkg::CMD_NEXT;
        end
      end
      pes_pkg::REQ_CLEAR: begin
        cnt_nxt = '0;
      end
      default: begin
        // unused code: plain ok
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (accept) begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== hw/rtl/pes_back.sv =====
// Back end: writes new entries and scans the table for the earliest event.
module pes_back #(
  parameter int MAX_USERS = pes_pkg::MAX_USERS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  pes_pkg::cmd_t      cmd,
  input  logic               cmd_empty,
  output logic               cmd_pop,
  input  logic               res_full,
  output logic               res_push,
  output pes_pkg::out_beat_t res
);

  localparam int CNTW = $clog2(MAX_USERS + 1);
  localparam int IDXW = $clog2(MAX_USERS);
  localparam int EW   = $bits(pes_pkg::entry_t);

  typedef enum logic [2:0] {
    BK_IDLE = 3'b001,
    BK_SCAN = 3'b010,
    BK_WB   = 3'b100
  } bk_state_t;

  bk_state_t       state_r, state_nxt;
  logic [CNTW-1:0] iss_r, iss_nxt;
  logic [CNTW-1:0] lim_r, lim_nxt;
  logic            rvld_r, rvld_nxt;
  logic [IDXW-1:0] ridx_r, ridx_nxt;
  logic            best_vld_r, best_vld_nxt;
  logic [IDXW-1:0] best_idx_r, best_idx_nxt;
  logic [31:0]     best_time_r, best_time_nxt;
  logic [15:0]     best_id_r, best_id_nxt;
  logic [15:0]     best_per_r, best_per_nxt;

  logic              we;
  logic [IDXW-1:0]   waddr;
  pes_pkg::entry_t   wentry;
  pes_pkg::entry_t   rentry;
  logic [EW-1:0]     rdata;
  logic              take;

  pes_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_USERS)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wentry),
    .raddr (iss_r[IDXW-1:0]),
    .rdata (rdata)
  );

  assign rentry = rdata;

  // earlier time wins, then lower id; ties keep the older entry
  assign take = !best_vld_r ||
                (rentry.next_time < best_time_r) ||
                ((rentry.next_time == best_time_r) && (rentry.id < best_id_r));

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    iss_nxt       = iss_r;
    lim_nxt       = lim_r;
    rvld_nxt      = 1'b0;
    ridx_nxt      = ridx_r;
    best_vld_nxt  = best_vld_r;
    best_idx_nxt  = best_idx_r;
    best_time_nxt = best_time_r;
    best_id_nxt   = best_id_r;
    best_per_nxt  = best_per_r;
    cmd_pop       = 1'b0;
    res_push      = 1'b0;
    res.status    = pes_pkg::ST_OK;
    res.event_id  = '0;
    res.event_time = '0;
    we            = 1'b0;
    waddr         = cmd.count[IDXW-1:0];
    wentry.id        = cmd.user_id;
    wentry.period    = cmd.period;
    wentry.next_time = {16'b0, cmd.period};

    case (state_r)
      BK_IDLE: begin
        // dispatch only with a free result slot; one result per command
        if (!cmd_empty && !res_full) begin
          cmd_pop = 1'b1;
          case (cmd.op)
            pes_pkg::CMD_ADD: begin
              we       = 1'b1;
              res_push = 1'b1;
            end
            pes_pkg::CMD_NEXT: begin
              lim_nxt      = cmd.count[CNTW-1:0];
              iss_nxt      = '0;
              best_vld_nxt = 1'b0;
              state_nxt    = BK_SCAN;
            end
            default: begin
              res_push   = 1'b1;
              res.status = cmd.status;
            end
          endcase
        end
      end
      BK_SCAN: begin
        // issue one read a cycle
        if (iss_r != lim_r) begin
          iss_nxt  = iss_r + CNTW'(1);
          rvld_nxt = 1'b1;
          ridx_nxt = iss_r[IDXW-1:0];
        end else if (!rvld_r) begin
          state_nxt = BK_WB;
        end
        // compare returned entry with the running best
        if (rvld_r && take) begin
          best_vld_nxt  = 1'b1;
          best_idx_nxt  = ridx_r;
          best_time_nxt = rentry.next_time;
          best_id_nxt   = rentry.id;
          best_per_nxt  = rentry.period;
        end
      end
      BK_WB: begin
        // report and advance the fired entry
        we               = 1'b1;
        waddr            = best_idx_r;
        wentry.id        = best_id_r;
        wentry.period    = best_per_r;
        wentry.next_time = best_time_r + {16'b0, best_per_r};
        res_push         = 1'b1;
        res.event_id     = best_id_r;
        res.event_time   = best_time_r;
        state_nxt        = BK_IDLE;
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= BK_IDLE;
      rvld_r     <= 1'b0;
      best_vld_r <= 1'b0;
      iss_r      <= '0;
      lim_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      rvld_r     <= rvld_nxt;
      best_vld_r <= best_vld_nxt;
      iss_r      <= iss_nxt;
      lim_r      <= lim_nxt;
    end
  end

  // scan datapath, no reset
  always_ff @(posedge clk) begin
    ridx_r      <= ridx_nxt;
    best_idx_r  <= best_idx_nxt;
    best_time_r <= best_time_nxt;
    best_id_r   <= best_id_nxt;
    best_per_r  <= best_per_nxt;
  end

endmodule

// ===== hw/rtl/periodic_event_scheduler.sv =====
// Periodic event scheduler top level: request queue in, result queue out.
//
// Each request beat gives exactly one result beat, in request order. A front
// end keeps the entry count and settles add, clear and error requests at once;
// a two-entry command queue feeds a back end that owns the entry table RAM.
// Add, clear, error and unused requests are reported in the same cycle that the
// back end pops them. For a next request the back end reads the stored entries
// one per cycle through the table RAM's single read port, keeps the earliest
// time (lower id on ties, older entry on full ties), then writes the fired
// entry back advanced by its period. The front keeps taking requests while the
// back end works, until the command queue fills. Firing times wrap modulo 2^32.
`include "assert_macros.svh"

module periodic_event_scheduler #(
  parameter int MAX_USERS = pes_pkg::MAX_USERS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  pes_pkg::in_beat_t  in_req,
  output logic               empty,
  input  logic               pop,
  output pes_pkg::out_beat_t out_res
);

  localparam int CMD_W = $bits(pes_pkg::cmd_t);
  localparam int RES_W = $bits(pes_pkg::out_beat_t);

  pes_pkg::cmd_t      cmd_in, cmd_out;
  pes_pkg::out_beat_t res_in;
  logic               cmd_empty, cmd_pop;
  logic               res_full, res_push;
  logic               accept;

  assign accept = push && !full;

  pes_front #(
    .MAX_USERS (MAX_USERS)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .req    (in_req),
    .cmd    (cmd_in)
  );

  pes_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (pes_pkg::Q_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (cmd_in),
    .full  (full),
    .pop   (cmd_pop),
    .rdata (cmd_out),
    .empty (cmd_empty)
  );

  pes_back #(
    .MAX_USERS (MAX_USERS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd_out),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  pes_fifo #(
    .WIDTH (RES_W),
    .DEPTH (pes_pkg::Q_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (out_res),
    .empty (empty)
  );

  // back end only dispatches with a command waiting and room for its result
  `PES_ASSERT_NOW(a_pop_has_room, cmd_pop, !cmd_empty && !res_full)
  // a result is never pushed into a full result queue
  `PES_ASSERT_NOW(a_push_not_full, res_push, !res_full)
  // a popped non-scan command reports in the same cycle
  `PES_ASSERT_NOW(a_quick_reply, cmd_pop && (cmd_out.op != pes_pkg::CMD_NEXT), res_push)

endmodule

// ===== test/periodic_event_scheduler_tb.sv =====
// Testbench for the periodic event scheduler: queued requests against a table predictor.
module periodic_event_scheduler_tb;

  localparam int TABLE_DEPTH = pes_pkg::MAX_USERS_DEF;
  // Request code with no meaning; the block must answer it with plain ok
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  // Cycles to linger after the last result: a full-table scan plus margin
  localparam int TAIL_CYCLES = 40;
  // Random stimulus size, and repeat count of the slow run (one user, period 65535)
  localparam int RANDOM_ITEMS = 1060;
  localparam int SLOW_NEXTS = 8;

  logic               clk;
  logic               rst_n;
  logic               push;
  logic               full;
  pes_pkg::in_beat_t  in_req;
  logic               empty;
  logic               pop;
  pes_pkg::out_beat_t out_res;

  periodic_event_scheduler #(.MAX_USERS(TABLE_DEPTH)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .full   (full),
    .in_req (in_req),
    .empty  (empty),
    .pop    (pop),
    .out_res(out_res)
  );

  // Shadow of the user table
  logic [15:0] tbl_id[TABLE_DEPTH];
  logic [15:0] tbl_period[TABLE_DEPTH];
  logic [31:0] tbl_time[TABLE_DEPTH];
  int          tbl_count;

  pes_pkg::in_beat_t  requests_to_send[$];
  pes_pkg::out_beat_t predicted_replies[$];
  pes_pkg::out_beat_t want;

  int     fail_count;
  int     mismatch_count;
  int     requests_sent;
  int     replies_checked;
  int     fired_count;
  int     full_count;
  int     empty_count;
  int     wrap_count;
  int     burst_left;
  int     gap_left;
  logic [15:0] stall_pattern;
  logic [3:0]  stall_phase;
  longint cycle_count;
  longint cycle_limit;

  // Earliest time wins, lower id on equal time, older slot on a full tie
  function automatic pes_pkg::out_beat_t schedule_request(pes_pkg::in_beat_t req);
    pes_pkg::out_beat_t res;
    int                 best;
    logic [31:0]        advanced;
    res = '0;
    res.status = pes_pkg::ST_OK;
    case (req.req_type)
      pes_pkg::REQ_ADD: begin
        if (tbl_count >= TABLE_DEPTH) begin
          res.status = pes_pkg::ST_FULL;
          full_count++;
        end else begin
          tbl_id[tbl_count]     = req.user_id;
          tbl_period[tbl_count] = req.period;
          tbl_time[tbl_count]   = {16'd0, req.period};
          tbl_count++;
        end
      end
      pes_pkg::REQ_NEXT: begin
        if (tbl_count == 0) begin
          res.status = pes_pkg::ST_EMPTY;
          empty_count++;
        end else begin
          best = 0;
          for (int i = 1; i < tbl_count; i++) begin
            if (tbl_time[i] < tbl_time[best] ||
                (tbl_time[i] == tbl_time[best] && tbl_id[i] < tbl_id[best]))
              best = i;
          end
          res.event_id   = tbl_id[best];
          res.event_time = tbl_time[best];
          advanced = tbl_time[best] + {16'd0, tbl_period[best]};
          if (advanced < tbl_time[best])
            wrap_count++;
          tbl_time[best] = advanced;
          fired_count++;
        end
      end
      pes_pkg::REQ_CLEAR: tbl_count = 0;
      default: ;
    endcase
    return res;
  endfunction

  task automatic queue_request(input logic [1:0] op, input logic [15:0] id,
                               input logic [15:0] per);
    pes_pkg::in_beat_t beat;
    beat.req_type = op;
    beat.user_id  = id;
    beat.period   = per;
    requests_to_send.push_back(beat);
  endtask

  // Add with a period drawn to hit zero, the top value and small clashing values
  task automatic queue_random_add(input bit narrow_ids);
    logic [15:0] id;
    logic [15:0] per;
    int          pick;
    id = narrow_ids ? 16'($urandom_range(0, 3)) : 16'($urandom_range(0, 65535));
    pick = $urandom_range(0, 15);
    if (pick == 0)
      per = 16'd0;
    else if (pick == 1)
      per = 16'hFFFF;
    else if (pick < 8)
      per = 16'($urandom_range(1, 4));
    else
      per = 16'($urandom_range(1, 65535));
    queue_request(pes_pkg::REQ_ADD, id, per);
  endtask

  task automatic report_mismatch(input string what);
    fail_count++;
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Cycle counter and run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > cycle_limit) begin
      $display("timeout after %0d cycles, %0d replies still pending",
               cycle_count, predicted_replies.size());
      $display("[periodic_event_scheduler] ERROR");
      $finish;
    end
  end

  // Request driver: bursts of beats with random gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else if (gap_left > 0) begin
      gap_left--;
      push <= 1'b0;
    end else if (requests_to_send.size() > 0) begin
      push   <= 1'b1;
      in_req <= requests_to_send[0];
    end else begin
      push <= 1'b0;
    end
  end

  // Accepted request beat: predict its reply, plan the next burst
  always @(posedge clk) begin
    if (rst_n && push && !full) begin
      predicted_replies.push_back(schedule_request(in_req));
      void'(requests_to_send.pop_front());
      requests_sent++;
      burst_left--;
      if (burst_left <= 0) begin
        if ($urandom_range(0, 4) == 0) begin
          burst_left = 64;
          gap_left   = 0;
        end else begin
          burst_left = $urandom_range(1, 12);
          gap_left   = $urandom_range(1, 6);
        end
      end
    end
  end

  // Reply receiver: pop follows a rotating stall pattern, redrawn now and then
  always @(negedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      pop <= stall_pattern[stall_phase];
      stall_phase <= stall_phase + 4'd1;
      if (stall_phase == 4'd15 && $urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pattern <= 16'hFFFF;
          1: stall_pattern <= 16'($urandom) | 16'h8421;
          2: stall_pattern <= 16'($urandom) | 16'h0001;
          default: stall_pattern <= 16'h00FF;
        endcase
      end
    end
  end

  // Reply monitor: compare each beat against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      replies_checked++;
      if (predicted_replies.size() == 0) begin
        report_mismatch($sformatf("reply with nothing pending: status %0d id %h time %h",
                                  out_res.status, out_res.event_id, out_res.event_time));
      end else begin
        want = predicted_replies.pop_front();
        if (out_res.status !== want.status)
          report_mismatch($sformatf("status exp %0d got %0d",
                                    want.status, out_res.status));
        if (out_res.event_id !== want.event_id)
          report_mismatch($sformatf("event_id exp %h got %h",
                                    want.event_id, out_res.event_id));
        if (out_res.event_time !== want.event_time)
          report_mismatch($sformatf("event_time exp %h got %h",
                                    want.event_time, out_res.event_time));
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int random_items;
    int adds;
    int nexts;
    bit narrow_ids;

    rst_n  = 1'b0;
    push   = 1'b0;
    pop    = 1'b0;
    in_req = '0;
    tbl_count       = 0;
    fail_count      = 0;
    mismatch_count  = 0;
    requests_sent   = 0;
    replies_checked = 0;
    fired_count     = 0;
    full_count      = 0;
    empty_count     = 0;
    wrap_count      = 0;
    burst_left      = 8;
    gap_left        = 0;
    stall_pattern   = 16'hFFFF;
    stall_phase     = 4'd0;
    cycle_count     = 0;
    cycle_limit     = 64'd100000000;

    // Directed: empty table, unused code, ties on time and id, zero period
    queue_request(pes_pkg::REQ_NEXT, 16'hFFFF, 16'hFFFF);
    queue_request(REQ_UNUSED, 16'hFFFF, 16'hFFFF);
    queue_request(pes_pkg::REQ_ADD, 16'h0000, 16'h0001);
    queue_request(pes_pkg::REQ_ADD, 16'h0007, 16'h0002);
    queue_request(pes_pkg::REQ_ADD, 16'h0000, 16'h0001);
    queue_request(pes_pkg::REQ_ADD, 16'h0003, 16'h0002);
    repeat (5) queue_request(pes_pkg::REQ_NEXT, 16'h0000, 16'h0000);
    queue_request(pes_pkg::REQ_CLEAR, 16'hFFFF, 16'hFFFF);
    queue_request(pes_pkg::REQ_NEXT, 16'h0000, 16'h0000);
    queue_request(pes_pkg::REQ_ADD, 16'h5555, 16'h0000);
    queue_request(pes_pkg::REQ_ADD, 16'hAAAA, 16'hFFFF);
    repeat (3) queue_request(pes_pkg::REQ_NEXT, 16'hAAAA, 16'h5555);
    queue_request(REQ_UNUSED, 16'h0000, 16'h0000);
    queue_request(pes_pkg::REQ_CLEAR, 16'h0000, 16'h0000);

    // One slow user with the top period fired a few times
    queue_request(pes_pkg::REQ_ADD, 16'hFFFF, 16'hFFFF);
    repeat (SLOW_NEXTS) queue_request(pes_pkg::REQ_NEXT, 16'h0000, 16'h0000);

    // Random: mostly fill-then-fire sequences, some loose noise
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) < 7) begin
        narrow_ids = $urandom_range(0, 1);
        if ($urandom_range(0, 3) != 0) begin
          queue_request(pes_pkg::REQ_CLEAR, 16'($urandom_range(0, 65535)),
                        16'($urandom_range(0, 65535)));
          random_items++;
        end
        adds  = $urandom_range(1, TABLE_DEPTH + 2);
        nexts = $urandom_range(1, 24);
        repeat (adds) queue_random_add(narrow_ids);
        random_items += adds;
        repeat (nexts) begin
          queue_request(pes_pkg::REQ_NEXT, 16'($urandom_range(0, 65535)),
                        16'($urandom_range(0, 65535)));
          random_items++;
          if ($urandom_range(0, 9) == 0) begin
            queue_random_add(narrow_ids);
            random_items++;
          end
        end
      end else begin
        repeat ($urandom_range(1, 6)) begin
          queue_request(2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)),
                        16'($urandom_range(0, 65535)));
          random_items++;
        end
      end
    end

    // Worst case per beat: full-table scan, longest gap and stall, many times over
    cycle_limit = longint'(requests_to_send.size()) * 120 + 2000;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (requests_to_send.size() > 0 || predicted_replies.size() > 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("ran %0d requests, checked %0d replies: %0d events fired, %0d time wraps",
             requests_sent, replies_checked, fired_count, wrap_count);
    $display("error replies covered: %0d full-table adds, %0d empty-table nexts",
             full_count, empty_count);
    if (fail_count == 0) begin
      $display("[periodic_event_scheduler] OK");
    end else begin
      $display("%0d failures", fail_count);
      $display("[periodic_event_scheduler] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/pes_pkg.sv
hw/rtl/pes_ram.sv
hw/rtl/pes_fifo.sv
hw/rtl/pes_front.sv
hw/rtl/pes_back.sv
hw/rtl/periodic_event_scheduler.sv
test/periodic_event_scheduler_tb.sv
